>>> src/sawq_pkg.sv
// ----------------------------------------------------------------------------
// sawq_pkg
// Shared constants, codes and command type of the slot allocator.
// ----------------------------------------------------------------------------
package sawq_pkg;

  localparam int TypeW = 3;
  localparam int IdW   = 16;
  localparam int SlotW = 5;
  localparam int CodeW = 4;
  localparam int CntW  = 5;

  localparam int SlotsDflt      = 16;
  localparam int QueueDepthDflt = 16;
  localparam int IdBitsDflt     = 16;

  localparam logic [CntW-1:0] SlotCountRst = 5'd16;

  // request type encodings
  localparam logic [TypeW-1:0] ReqArrive  = 3'd0;
  localparam logic [TypeW-1:0] ReqRelease = 3'd1;
  localparam logic [TypeW-1:0] ReqQDump   = 3'd2;
  localparam logic [TypeW-1:0] ReqSDump   = 3'd3;

  typedef enum logic [CodeW-1:0] {
    RES_GRANTED  = 4'd0,
    RES_QUEUED   = 4'd1,
    RES_HANDED   = 4'd2,
    RES_FREED    = 4'd3,
    RES_ENTRY    = 4'd4,
    RES_EMPTY    = 4'd5,
    RES_SLOT     = 4'd6,
    RES_UNKNOWN  = 4'd7,
    RES_FULL     = 4'd8,
    RES_BAD_SLOT = 4'd9
  } sawq_code_e;

  typedef enum logic [2:0] {
    OP_ARRIVE,
    OP_RELEASE,
    OP_BAD_SLOT,
    OP_QDUMP,
    OP_SDUMP,
    OP_UNKNOWN
  } sawq_op_e;

  typedef struct packed {
    sawq_op_e          op;
    logic [IdW-1:0]    id;
    logic [SlotW-1:0]  slot;
  } sawq_cmd_t;

endpackage

>>> src/sawq_front.sv
// ----------------------------------------------------------------------------
// sawq_front
// Request decode: classifies each input word into a back-end command.
// ----------------------------------------------------------------------------
module sawq_front import sawq_pkg::*; #(
  parameter int ID_BITS = IdBitsDflt
) (
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [TypeW-1:0]   req_type_i,
  input  logic [IdW-1:0]     requester_id_i,
  input  logic [SlotW-1:0]   slot_number_i,
  input  logic [CntW-1:0]    n_eff_i,
  input  logic               full_i,
  output logic               push_o,
  output sawq_cmd_t          cmd_o
);

  localparam int StoreW = (ID_BITS < IdW) ? ID_BITS : IdW;

  assign req_ready_o = !full_i;
  assign push_o      = req_valid_i && !full_i;

  always_comb begin
    cmd_o.id   = IdW'(requester_id_i[StoreW-1:0]);
    cmd_o.slot = slot_number_i;
    case (req_type_i)
      ReqArrive:  cmd_o.op = OP_ARRIVE;
      ReqRelease: begin
        // slot numbers are one-based; zero or past the active count is bad
        if (slot_number_i == '0 || slot_number_i > n_eff_i) begin
          cmd_o.op = OP_BAD_SLOT;
        end else begin
          cmd_o.op = OP_RELEASE;
        end
      end
      ReqQDump:   cmd_o.op = OP_QDUMP;
      ReqSDump:   cmd_o.op = OP_SDUMP;
      default:    cmd_o.op = OP_UNKNOWN;
    endcase
  end

endmodule

>>> src/sawq_cmdq.sv
// ----------------------------------------------------------------------------
// sawq_cmdq
// Two-entry command queue between decode and execution.
// ----------------------------------------------------------------------------
module sawq_cmdq import sawq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sawq_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sawq_cmd_t cmd_o
);

  sawq_cmd_t   entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> src/sawq_back.sv
// ----------------------------------------------------------------------------
// sawq_back
// Execution: slot flags, occupant and wait-queue memories, dump sequencer
// and the result output register.
// ----------------------------------------------------------------------------
module sawq_back import sawq_pkg::*; #(
  parameter int SLOTS       = SlotsDflt,
  parameter int QUEUE_DEPTH = QueueDepthDflt,
  parameter int ID_BITS     = IdBitsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CntW-1:0]   n_eff_i,
  input  logic              cmd_valid_i,
  input  sawq_cmd_t         cmd_i,
  output logic              cmd_pop_o,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic [CodeW-1:0]  result_code_o,
  output logic [IdW-1:0]    result_id_o,
  output logic [SlotW-1:0]  result_slot_o,
  output logic              slot_busy_o,
  output logic              last_o
);

  localparam int StoreW = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int FW     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_HAND, ST_QDUMP, ST_SDUMP} state_e;

  typedef struct packed {
    sawq_code_e        code;
    logic [IdW-1:0]    id;
    logic [SlotW-1:0]  slot;
    logic              busy;
    logic              last;
  } res_t;

  state_e              state_q, state_d;
  logic [SLOTS-1:0]    busy_q, busy_d;
  logic [QW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [QW-1:0]       qptr_q, qptr_d;
  logic [FW-1:0]       qrem_q, qrem_d;
  logic [SW-1:0]       sptr_q, sptr_d;
  logic [SlotW-1:0]    hslot_q, hslot_d;
  logic                rvalid_q, rvalid_d;
  res_t                res_q, res_d;

  logic [StoreW-1:0]   wq_mem [QUEUE_DEPTH];
  logic [StoreW-1:0]   occ_mem [SLOTS];
  logic [StoreW-1:0]   wq_rdata_q, occ_rdata_q;
  logic                wq_we, occ_we;
  logic [QW-1:0]       wq_waddr, wq_raddr;
  logic [SW-1:0]       occ_waddr, occ_raddr;
  logic [StoreW-1:0]   wq_wdata, occ_wdata;

  logic                out_free;
  logic                free_found;
  logic [SW-1:0]       free_idx;
  logic [SW-1:0]       rel_idx, hand_idx;
  logic [SlotW-1:0]    sdump_slot;

  function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] p);
    q_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free   = !rvalid_q || result_ready_i;
  assign rel_idx    = SW'(cmd_i.slot - 5'd1);
  assign hand_idx   = SW'(hslot_q - 5'd1);
  assign sdump_slot = SlotW'(sptr_q) + 5'd1;

  // lowest free slot among the active ones
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i] && (i < int'(n_eff_i))) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    qptr_d    = qptr_q;
    qrem_d    = qrem_q;
    sptr_d    = sptr_q;
    hslot_d   = hslot_q;
    rvalid_d  = rvalid_q && !result_ready_i;
    res_d     = res_q;
    cmd_pop_o = 1'b0;
    wq_we     = 1'b0;
    wq_waddr  = tail_q;
    wq_wdata  = cmd_i.id[StoreW-1:0];
    wq_raddr  = head_q;
    occ_we    = 1'b0;
    occ_waddr = free_idx;
    occ_wdata = cmd_i.id[StoreW-1:0];
    occ_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          rvalid_d  = 1'b1;
          res_d     = '{RES_UNKNOWN, '0, '0, 1'b0, 1'b1};
          case (cmd_i.op)
            OP_ARRIVE: begin
              if (free_found) begin
                busy_d[free_idx] = 1'b1;
                occ_we           = 1'b1;
                res_d = '{RES_GRANTED, cmd_i.id, SlotW'(free_idx) + 5'd1, 1'b0, 1'b1};
              end else if (fill_q == FW'(QUEUE_DEPTH)) begin
                res_d = '{RES_FULL, cmd_i.id, '0, 1'b0, 1'b1};
              end else begin
                wq_we  = 1'b1;
                tail_d = q_inc(tail_q);
                fill_d = fill_q + 1'b1;
                res_d  = '{RES_QUEUED, cmd_i.id, '0, 1'b0, 1'b1};
              end
            end
            OP_RELEASE: begin
              if (fill_q != '0) begin
                // head id is read this cycle, handed over in ST_HAND once the output register is free
                rvalid_d = rvalid_q && !result_ready_i;
                hslot_d  = cmd_i.slot;
                state_d  = ST_HAND;
              end else begin
                busy_d[rel_idx] = 1'b0;
                res_d = '{RES_FREED, '0, cmd_i.slot, 1'b0, 1'b1};
              end
            end
            OP_BAD_SLOT: begin
              res_d = '{RES_BAD_SLOT, '0, cmd_i.slot, 1'b0, 1'b1};
            end
            OP_QDUMP: begin
              if (fill_q == '0) begin
                res_d = '{RES_EMPTY, '0, '0, 1'b0, 1'b1};
              end else begin
                rvalid_d = rvalid_q && !result_ready_i;
                qptr_d   = head_q;
                qrem_d   = fill_q;
                state_d  = ST_QDUMP;
              end
            end
            OP_SDUMP: begin
              rvalid_d = rvalid_q && !result_ready_i;
              sptr_d   = '0;
              state_d  = ST_SDUMP;
            end
            default: begin
              res_d = '{RES_UNKNOWN, '0, '0, 1'b0, 1'b1};
            end
          endcase
        end
      end
      ST_HAND: begin
        if (out_free) begin
          rvalid_d          = 1'b1;
          res_d             = '{RES_HANDED, IdW'(wq_rdata_q), hslot_q, 1'b0, 1'b1};
          occ_we            = 1'b1;
          occ_waddr         = hand_idx;
          occ_wdata         = wq_rdata_q;
          busy_d[hand_idx]  = 1'b1;
          head_d            = q_inc(head_q);
          fill_d            = fill_q - 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_QDUMP: begin
        // read data always holds the entry at qptr_q
        wq_raddr = qptr_q;
        if (out_free) begin
          rvalid_d = 1'b1;
          res_d    = '{RES_ENTRY, IdW'(wq_rdata_q), '0, 1'b0, qrem_q == FW'(1)};
          qptr_d   = q_inc(qptr_q);
          wq_raddr = q_inc(qptr_q);
          qrem_d   = qrem_q - 1'b1;
          if (qrem_q == FW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SDUMP: begin
        occ_raddr = sptr_q;
        if (out_free) begin
          rvalid_d  = 1'b1;
          res_d     = '{RES_SLOT, busy_q[sptr_q] ? IdW'(occ_rdata_q) : '0, sdump_slot,
                        busy_q[sptr_q], sdump_slot == n_eff_i};
          sptr_d    = sptr_q + 1'b1;
          occ_raddr = sptr_q + 1'b1;
          if (sdump_slot == n_eff_i) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      qptr_q   <= '0;
      qrem_q   <= '0;
      sptr_q   <= '0;
      hslot_q  <= '0;
      rvalid_q <= 1'b0;
      res_q    <= '{RES_GRANTED, '0, '0, 1'b0, 1'b0};
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      qptr_q   <= qptr_d;
      qrem_q   <= qrem_d;
      sptr_q   <= sptr_d;
      hslot_q  <= hslot_d;
      rvalid_q <= rvalid_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wq_we) begin
      wq_mem[wq_waddr] <= wq_wdata;
    end
    wq_rdata_q <= wq_mem[wq_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rdata_q <= occ_mem[occ_raddr];
  end

  assign result_valid_o = rvalid_q;
  assign result_code_o  = res_q.code;
  assign result_id_o    = res_q.id;
  assign result_slot_o  = res_q.slot;
  assign slot_busy_o    = res_q.busy;
  assign last_o         = res_q.last;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH))
    else $error("wait queue fill above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == FW'(QUEUE_DEPTH)) |-> head_q == tail_q)
    else $error("queue pointers disagree with fill count");

  a_hand_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HAND || state_q == ST_QDUMP) |-> fill_q != '0)
    else $error("queue read with empty queue");

  a_hand_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HAND && out_free) |=> fill_q == $past(fill_q) - 1'b1)
    else $error("handover did not dequeue");
`endif

endmodule

>>> src/slot_allocator_with_wait_queue_top.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_wait_queue_top
// Slot allocator with a FIFO wait queue: decode front, command queue,
// execution back end.
// ----------------------------------------------------------------------------
// Requests arrive as words on the req channel and each produces one or more
// result words on the result channel, the final one flagged by last_o. The
// front decodes a word in the cycle it is accepted and parks it in a
// two-entry command queue, so requests keep flowing while the back end is
// busy or the result side stalls. The back end registers the result of an
// arrival, free, bad-slot or unknown request as it pops the command. A release
// that hands the slot to a waiting requester goes through a hand-over state,
// since the head id comes from the wait-queue memory with a registered read.
// A queue dump starts its memory read and then lists the entries in order;
// a slot dump likewise steps through the active slots, each step reading the
// occupant memory. The result register is refilled in the cycle it drains.
// slot_count is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Zero acts as one and values above SLOTS act as SLOTS. Occupant and
// wait-queue memories are not cleared at reset; only written entries are ever shown.
module slot_allocator_with_wait_queue_top import sawq_pkg::*; #(
  parameter int SLOTS       = SlotsDflt,
  parameter int QUEUE_DEPTH = QueueDepthDflt,
  parameter int ID_BITS     = IdBitsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [TypeW-1:0]  req_type_i,
  input  logic [IdW-1:0]    requester_id_i,
  input  logic [SlotW-1:0]  slot_number_i,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic [CodeW-1:0]  result_code_o,
  output logic [IdW-1:0]    result_id_o,
  output logic [SlotW-1:0]  result_slot_o,
  output logic              slot_busy_o,
  output logic              last_o
);

  logic [CntW-1:0] slot_count_q;
  logic [CntW-1:0] n_eff;

  logic       push, cmdq_full, cmd_valid, cmd_pop;
  sawq_cmd_t  push_cmd, head_cmd;

  // slot count register, reset to the full default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  // effective slot count, clamped to 1..SLOTS
  always_comb begin
    if (slot_count_q == '0) begin
      n_eff = CntW'(1);
    end else if (int'(slot_count_q) > SLOTS) begin
      n_eff = CntW'(SLOTS);
    end else begin
      n_eff = slot_count_q;
    end
  end

  sawq_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .req_valid_i    (req_valid_i),
    .req_ready_o    (req_ready_o),
    .req_type_i     (req_type_i),
    .requester_id_i (requester_id_i),
    .slot_number_i  (slot_number_i),
    .n_eff_i        (n_eff),
    .full_i         (cmdq_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sawq_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  sawq_back #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_eff_i        (n_eff),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .result_code_o  (result_code_o),
    .result_id_o    (result_id_o),
    .result_slot_o  (result_slot_o),
    .slot_busy_o    (slot_busy_o),
    .last_o         (last_o)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slot allocator with its FIFO wait queue.
// Request words go in over a valid/ready channel and result words come back
// over another. A scoreboard keeps its own copy of the slot table and the
// wait queue, predicts every result word of each accepted request and checks
// the returned words in order. Directed cases come first, then random traffic
// over several slot counts, with random stalls on both sides in stages 1 and 2.
// ----------------------------------------------------------------------------
import sawq_pkg::*;

typedef struct packed {
  sawq_code_e       code;
  logic [IdW-1:0]   id;
  logic [SlotW-1:0] slot;
  logic             busy;
  logic             last;
} alloc_word_t;

class slot_alloc_scoreboard;
  alloc_word_t      due_words[$];
  logic [CntW-1:0]  slot_count;
  bit               busy[SlotsDflt];
  logic [IdW-1:0]   occupant[SlotsDflt];
  logic [IdW-1:0]   waiting[QueueDepthDflt];
  int               q_head;
  int               q_tail;
  int               q_fill;
  int               fail_cnt;

  function new();
    slot_count = SlotCountRst;
    foreach (busy[i]) busy[i] = 1'b0;
    q_head   = 0;
    q_tail   = 0;
    q_fill   = 0;
    fail_cnt = 0;
  endfunction

  function void set_slot_count(logic [CntW-1:0] value);
    slot_count = value;
  endfunction

  // zero acts as one, anything above the built size as the built size
  function int active_slots();
    if (slot_count == '0) return 1;
    if (int'(slot_count) > SlotsDflt) return SlotsDflt;
    return int'(slot_count);
  endfunction

  function int pending();
    return due_words.size();
  endfunction

  task report(string msg);
    fail_cnt++;
    $display("MISMATCH: %s", msg);
  endtask

  function void push_word(sawq_code_e code, logic [IdW-1:0] id, logic [SlotW-1:0] slot,
                          logic busy_flag, logic last_flag);
    alloc_word_t w;
    w.code = code;
    w.id   = id;
    w.slot = slot;
    w.busy = busy_flag;
    w.last = last_flag;
    due_words = {due_words, w};
  endfunction

  // Advance the allocator state by one accepted request word and queue the
  // result words it must produce.
  function void note_request(logic [TypeW-1:0] kind, logic [IdW-1:0] id,
                             logic [SlotW-1:0] slot);
    int            n;
    int            s;
    logic [IdW-1:0] head_id;
    n = active_slots();
    s = int'(slot);
    case (kind)
      ReqArrive: begin
        for (int i = 0; i < n; i++) begin
          if (!busy[i]) begin
            busy[i]     = 1'b1;
            occupant[i] = id;
            push_word(RES_GRANTED, id, SlotW'(i + 1), 1'b0, 1'b1);
            return;
          end
        end
        if (q_fill >= QueueDepthDflt) begin
          push_word(RES_FULL, id, '0, 1'b0, 1'b1);
        end else begin
          waiting[q_tail] = id;
          q_tail = (q_tail + 1) % QueueDepthDflt;
          q_fill++;
          push_word(RES_QUEUED, id, '0, 1'b0, 1'b1);
        end
      end
      ReqRelease: begin
        if (s == 0 || s > n) begin
          push_word(RES_BAD_SLOT, '0, slot, 1'b0, 1'b1);
        end else if (q_fill > 0) begin
          // slot goes to the queue head, busy even if it was free
          head_id = waiting[q_head];
          q_head  = (q_head + 1) % QueueDepthDflt;
          q_fill--;
          occupant[s-1] = head_id;
          busy[s-1]     = 1'b1;
          push_word(RES_HANDED, head_id, slot, 1'b0, 1'b1);
        end else begin
          busy[s-1] = 1'b0;
          push_word(RES_FREED, '0, slot, 1'b0, 1'b1);
        end
      end
      ReqQDump: begin
        if (q_fill == 0) begin
          push_word(RES_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < q_fill; i++) begin
            push_word(RES_ENTRY, waiting[(q_head + i) % QueueDepthDflt], '0, 1'b0,
                      i + 1 == q_fill);
          end
        end
      end
      ReqSDump: begin
        for (int i = 0; i < n; i++) begin
          push_word(RES_SLOT, busy[i] ? occupant[i] : '0, SlotW'(i + 1), busy[i],
                    i + 1 == n);
        end
      end
      default: push_word(RES_UNKNOWN, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  task check_result(logic [CodeW-1:0] code, logic [IdW-1:0] id,
                    logic [SlotW-1:0] slot, logic busy_flag, logic last_flag);
    alloc_word_t w;
    if (due_words.size() == 0) begin
      report($sformatf("result word with none due: code %0d id %h slot %0d",
                       code, id, slot));
      return;
    end
    w = due_words[0];
    due_words.delete(0);
    if (code !== w.code)
      report($sformatf("code %0d, due %0d (%s)", code, w.code, w.code.name()));
    if (id !== w.id)
      report($sformatf("id %h, due %h (code %s)", id, w.id, w.code.name()));
    if (slot !== w.slot)
      report($sformatf("slot %0d, due %0d (code %s)", slot, w.slot, w.code.name()));
    if (busy_flag !== w.busy)
      report($sformatf("busy %b, due %b (code %s)", busy_flag, w.busy, w.code.name()));
    if (last_flag !== w.last)
      report($sformatf("last %b, due %b (code %s)", last_flag, w.last, w.code.name()));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // highest request type; everything above ReqSDump is undecoded
  localparam int ReqTypeTop = (1 << TypeW) - 1;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CntW-1:0]   cfg_wdata_i    = '0;
  logic              req_valid_i    = 1'b0;
  logic              req_ready_o;
  logic [TypeW-1:0]  req_type_i     = '0;
  logic [IdW-1:0]    requester_id_i = '0;
  logic [SlotW-1:0]  slot_number_i  = '0;
  logic              result_valid_o;
  logic              result_ready_i = 1'b0;
  logic [CodeW-1:0]  result_code_o;
  logic [IdW-1:0]    result_id_o;
  logic [SlotW-1:0]  result_slot_o;
  logic              slot_busy_o;
  logic              last_o;

  // stall percentages of the request sender and the result receiver
  int send_idle_pct = 27;
  int recv_idle_pct = 60;

  slot_alloc_scoreboard sb;

  slot_allocator_with_wait_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_valid_i    (req_valid_i),
    .req_ready_o    (req_ready_o),
    .req_type_i     (req_type_i),
    .requester_id_i (requester_id_i),
    .slot_number_i  (slot_number_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .result_code_o  (result_code_o),
    .result_id_o    (result_id_o),
    .result_slot_o  (result_slot_o),
    .slot_busy_o    (slot_busy_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check every word taken at this edge, then pick the ready
  // for the next cycle. Outputs are read before the edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i) begin
      sb.check_result(result_code_o, result_id_o, result_slot_o, slot_busy_o, last_o);
    end
    result_ready_i <= rst_ni && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Present one request word and hold it until taken. Valid is only lowered
  // when a gap is inserted, so back-to-back words keep it high.
  task automatic send_req(input logic [TypeW-1:0] kind, input logic [IdW-1:0] id,
                          input logic [SlotW-1:0] slot);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    req_valid_i    <= 1'b1;
    req_type_i     <= kind;
    requester_id_i <= id;
    slot_number_i  <= slot;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    sb.note_request(kind, id, slot);
  endtask

  // wait until every due result word is back, plus the back end's latency
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // slot_count may only change while the block is idle
  task automatic write_slot_count(input logic [CntW-1:0] value);
    req_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_slot_count(value);
  endtask

  // Random traffic, arrival-heavy so the queue fills and wraps. Releases
  // mostly name a live slot; a few take any 5-bit value to hit bad slots.
  task automatic send_random(input int count);
    int               roll;
    logic [TypeW-1:0] kind;
    logic [IdW-1:0]   id;
    logic [SlotW-1:0] slot;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99, 0);
      id   = IdW'($urandom);
      slot = SlotW'($urandom_range((1 << SlotW) - 1, 0));
      if (roll < 50) begin
        kind = ReqArrive;
      end else if (roll < 76) begin
        kind = ReqRelease;
        slot = SlotW'($urandom_range(sb.active_slots(), 1));
      end else if (roll < 84) begin
        kind = ReqRelease;
      end else if (roll < 90) begin
        kind = ReqQDump;
      end else if (roll < 94) begin
        kind = ReqSDump;
      end else begin
        kind = TypeW'($urandom_range(ReqTypeTop, int'(ReqSDump) + 1));
      end
      send_req(kind, id, slot);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- stage 1: sender idles 27%, receiver 60% ----
    // reset slot count: full slot listing, empty queue, undecoded types
    send_req(ReqSDump, '0, '0);
    send_req(ReqQDump, '0, '0);
    for (int t = int'(ReqSDump) + 1; t <= ReqTypeTop; t++) begin
      send_req(TypeW'(t), '1, '1);
    end

    // one slot: grant, free, free an already free slot, grant again
    write_slot_count(CntW'(1));
    send_req(ReqArrive, '0, '0);
    send_req(ReqRelease, '1, SlotW'(1));
    send_req(ReqRelease, '0, SlotW'(1));
    send_req(ReqArrive, '1, '1);
    // sixteen waiters fill the queue, the seventeenth is dropped
    for (int k = 0; k <= QueueDepthDflt; k++) begin
      send_req(ReqArrive, IdW'($urandom), SlotW'($urandom_range(31, 0)));
    end
    send_req(ReqQDump, '0, '0);
    // bad slots: zero, one past the count, all ones
    send_req(ReqRelease, '0, '0);
    send_req(ReqRelease, '0, SlotW'(2));
    send_req(ReqRelease, '0, '1);

    // growing the count exposes a free slot while the queue is not empty:
    // releasing it hands it over all the same
    write_slot_count(CntW'(2));
    send_req(ReqRelease, '0, SlotW'(2));
    send_req(ReqSDump, '0, '0);
    send_req(ReqRelease, '0, SlotW'(1));

    write_slot_count('0);
    send_random(15);

    // ---- stage 2: sender idles 60%, receiver 27% ----
    write_slot_count('1);
    send_idle_pct = 60;
    recv_idle_pct = 27;
    send_random(25);
    write_slot_count(CntW'(3));
    send_random(25);

    // ---- stage 3: no stalls on either side ----
    write_slot_count(CntW'(SlotsDflt));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(15);
    write_slot_count(CntW'(2));
    send_random(15);

    req_valid_i <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
src/sawq_pkg.sv
src/sawq_front.sv
src/sawq_cmdq.sv
src/sawq_back.sv
src/slot_allocator_with_wait_queue_top.sv
tb/tb_top.sv
